// File: src/nnps_pkg.sv
package nnps_pkg;

   localparam int unsigned COORD_WIDTH  = 12;
   localparam int unsigned SIZE_WIDTH   = 13;
   localparam int unsigned STRIDE_WIDTH = 14;
   localparam int unsigned OFFSET_WIDTH = 25;
   localparam int unsigned CSR_WIDTH    = 14;
   localparam int unsigned NUM_WIDTH    = 24;  // coordinate times size
   localparam int unsigned QUO_WIDTH    = COORD_WIDTH;

   localparam logic [SIZE_WIDTH-1:0]   MAX_DIMENSION = SIZE_WIDTH'(4096);
   localparam logic [STRIDE_WIDTH-1:0] MAX_STRIDE    = STRIDE_WIDTH'(8192);

   localparam logic [SIZE_WIDTH-1:0]   RESET_SOURCE_WIDTH   = SIZE_WIDTH'(1920);
   localparam logic [SIZE_WIDTH-1:0]   RESET_SOURCE_HEIGHT  = SIZE_WIDTH'(1080);
   localparam logic [SIZE_WIDTH-1:0]   RESET_TARGET_WIDTH   = SIZE_WIDTH'(1920);
   localparam logic [SIZE_WIDTH-1:0]   RESET_TARGET_HEIGHT  = SIZE_WIDTH'(1080);
   localparam logic [STRIDE_WIDTH-1:0] RESET_LUMA_STRIDE    = STRIDE_WIDTH'(1920);
   localparam logic [STRIDE_WIDTH-1:0] RESET_CHROMA_STRIDE  = STRIDE_WIDTH'(960);

   typedef enum logic [2:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT,
      REG_TARGET_WIDTH,
      REG_TARGET_HEIGHT,
      REG_LUMA_SOURCE_STRIDE,
      REG_CHROMA_SOURCE_STRIDE,
      REG_LUMA_TARGET_STRIDE,
      REG_CHROMA_TARGET_STRIDE
   } csr_index_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] target_column;
      logic [COORD_WIDTH-1:0] target_row;
      logic                   chroma_plane;
   } nnps_req_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]  source_column;
      logic [COORD_WIDTH-1:0]  source_row;
      logic [OFFSET_WIDTH-1:0] source_offset;
      logic [OFFSET_WIDTH-1:0] target_offset;
      logic                    bad_request;
   } nnps_rsp_type;

endpackage

// File: src/nearest_neighbor_plane_scaler_core.sv
// Nearest-neighbor address generator for I420 planes. Each item names one
// destination pixel (column, row, luma or chroma plane) and returns the nearest
// source column and row plus the byte offsets of source and destination pixel
// within their planes. Chroma uses the luma sizes halved; U and V share strides.
// Throughput is one item per clock while the result side does not stall. The
// pipeline is built around the restoring divider, which resolves one quotient
// bit per pipeline stage over 12 stages, framed by a plane-select stage, a
// multiply stage, and an offset multiply and add stage pair. Stalls on the
// result side fill empty stages first. The user must write registers only while
// no items are in flight; the block itself does not enforce this.
module nearest_neighbor_plane_scaler_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  nnps_pkg::nnps_req_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output nnps_pkg::nnps_rsp_type       rsp_data,
   input  logic                         csr_write_enable,
   input  nnps_pkg::csr_index_type      csr_index,
   input  logic [nnps_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import nnps_pkg::*;

   localparam int unsigned DIV_STAGES = QUO_WIDTH;
   localparam int unsigned NUM_STAGES = DIV_STAGES + 4;
   localparam int unsigned MUL_STAGE  = DIV_STAGES + 2;
   localparam int unsigned OUT_STAGE  = DIV_STAGES + 3;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]  dx;
      logic [COORD_WIDTH-1:0]  dy;
      logic [SIZE_WIDTH-1:0]   sw;
      logic [SIZE_WIDTH-1:0]   sh;
      logic [SIZE_WIDTH-1:0]   dw;
      logic [SIZE_WIDTH-1:0]   dh;
      logic [STRIDE_WIDTH-1:0] sstride;
      logic [STRIDE_WIDTH-1:0] dstride;
      logic                    bad;
   } front_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0]    rem_x;
      logic [NUM_WIDTH-1:0]    rem_y;
      logic [QUO_WIDTH-1:0]    q_x;
      logic [QUO_WIDTH-1:0]    q_y;
      logic [SIZE_WIDTH-1:0]   dw;
      logic [SIZE_WIDTH-1:0]   dh;
      logic [COORD_WIDTH-1:0]  dx;
      logic [STRIDE_WIDTH-1:0] sstride;
      logic [OFFSET_WIDTH-1:0] prod_t;
      logic                    bad;
   } div_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]  sx;
      logic [COORD_WIDTH-1:0]  sy;
      logic [OFFSET_WIDTH-1:0] prod_s;
      logic [OFFSET_WIDTH-1:0] target_offset;
      logic                    bad;
   } mul_type;

   function automatic logic [SIZE_WIDTH-1:0] clamp_size(input logic [SIZE_WIDTH-1:0] v);
      return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
   endfunction

   function automatic logic [STRIDE_WIDTH-1:0] clamp_stride(
      input logic [STRIDE_WIDTH-1:0] v);
      return (v > MAX_STRIDE) ? MAX_STRIDE : v;
   endfunction

   // configuration registers
   logic [SIZE_WIDTH-1:0]   source_width_ff, source_height_ff;
   logic [SIZE_WIDTH-1:0]   target_width_ff, target_height_ff;
   logic [STRIDE_WIDTH-1:0] luma_source_stride_ff, chroma_source_stride_ff;
   logic [STRIDE_WIDTH-1:0] luma_target_stride_ff, chroma_target_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff         <= RESET_SOURCE_WIDTH;
         source_height_ff        <= RESET_SOURCE_HEIGHT;
         target_width_ff         <= RESET_TARGET_WIDTH;
         target_height_ff        <= RESET_TARGET_HEIGHT;
         luma_source_stride_ff   <= RESET_LUMA_STRIDE;
         chroma_source_stride_ff <= RESET_CHROMA_STRIDE;
         luma_target_stride_ff   <= RESET_LUMA_STRIDE;
         chroma_target_stride_ff <= RESET_CHROMA_STRIDE;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SOURCE_WIDTH:         source_width_ff  <= csr_write_data[SIZE_WIDTH-1:0];
            REG_SOURCE_HEIGHT:        source_height_ff <= csr_write_data[SIZE_WIDTH-1:0];
            REG_TARGET_WIDTH:         target_width_ff  <= csr_write_data[SIZE_WIDTH-1:0];
            REG_TARGET_HEIGHT:        target_height_ff <= csr_write_data[SIZE_WIDTH-1:0];
            REG_LUMA_SOURCE_STRIDE:   luma_source_stride_ff   <= csr_write_data;
            REG_CHROMA_SOURCE_STRIDE: chroma_source_stride_ff <= csr_write_data;
            REG_LUMA_TARGET_STRIDE:   luma_target_stride_ff   <= csr_write_data;
            REG_CHROMA_TARGET_STRIDE: chroma_target_stride_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage handshake: a stage takes new data when empty or when it drains
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] upstream_valid;
   logic [NUM_STAGES:0]   en;

   assign en[NUM_STAGES]  = rsp_ready;
   assign upstream_valid  = {valid_ff[NUM_STAGES-2:0], req_valid};

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
      assign en[k] = ~valid_ff[k] | en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) valid_ff[k] <= upstream_valid[k];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[OUT_STAGE];

   // stage 0: plane geometry and range check
   front_type front_in, front_ff;
   logic [SIZE_WIDTH-1:0] sw_c, sh_c, dw_c, dh_c;

   always_comb begin
      sw_c = clamp_size(source_width_ff);
      sh_c = clamp_size(source_height_ff);
      dw_c = clamp_size(target_width_ff);
      dh_c = clamp_size(target_height_ff);
      front_in.dx = req_data.target_column;
      front_in.dy = req_data.target_row;
      if (req_data.chroma_plane) begin
         front_in.sw      = sw_c >> 1;
         front_in.sh      = sh_c >> 1;
         front_in.dw      = dw_c >> 1;
         front_in.dh      = dh_c >> 1;
         front_in.sstride = clamp_stride(chroma_source_stride_ff);
         front_in.dstride = clamp_stride(chroma_target_stride_ff);
      end else begin
         front_in.sw      = sw_c;
         front_in.sh      = sh_c;
         front_in.dw      = dw_c;
         front_in.dh      = dh_c;
         front_in.sstride = clamp_stride(luma_source_stride_ff);
         front_in.dstride = clamp_stride(luma_target_stride_ff);
      end
      front_in.bad = (front_in.sw == '0) || (front_in.sh == '0) ||
                     (front_in.dw == '0) || (front_in.dh == '0) ||
                     ({1'b0, front_in.dx} >= front_in.dw) ||
                     ({1'b0, front_in.dy} >= front_in.dh);
   end

   always_ff @(posedge clock) begin
      if (en[0]) front_ff <= front_in;
   end

   // stage 1: products; stages 2..13: one quotient bit each
   div_type div_in [DIV_STAGES+1];
   div_type div_ff [DIV_STAGES+1];
   logic [COORD_WIDTH+SIZE_WIDTH-1:0]   num_x, num_y;
   logic [COORD_WIDTH+STRIDE_WIDTH-1:0] prod_t;

   always_comb begin
      num_x  = front_ff.dx * front_ff.sw;
      num_y  = front_ff.dy * front_ff.sh;
      prod_t = front_ff.dy * front_ff.dstride;
      div_in[0].rem_x   = num_x[NUM_WIDTH-1:0];
      div_in[0].rem_y   = num_y[NUM_WIDTH-1:0];
      div_in[0].q_x     = '0;
      div_in[0].q_y     = '0;
      div_in[0].dw      = front_ff.dw;
      div_in[0].dh      = front_ff.dh;
      div_in[0].dx      = front_ff.dx;
      div_in[0].sstride = front_ff.sstride;
      div_in[0].prod_t  = prod_t[OFFSET_WIDTH-1:0];
      div_in[0].bad     = front_ff.bad;
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int unsigned BIT = QUO_WIDTH - 1 - j;
      logic [NUM_WIDTH:0] dvx, dvy;
      logic               take_x, take_y;

      always_comb begin
         dvx    = {{(NUM_WIDTH+1-SIZE_WIDTH){1'b0}}, div_ff[j].dw} << BIT;
         dvy    = {{(NUM_WIDTH+1-SIZE_WIDTH){1'b0}}, div_ff[j].dh} << BIT;
         take_x = {1'b0, div_ff[j].rem_x} >= dvx;
         take_y = {1'b0, div_ff[j].rem_y} >= dvy;
         div_in[j+1] = div_ff[j];
         if (take_x) div_in[j+1].rem_x = div_ff[j].rem_x - dvx[NUM_WIDTH-1:0];
         if (take_y) div_in[j+1].rem_y = div_ff[j].rem_y - dvy[NUM_WIDTH-1:0];
         div_in[j+1].q_x[BIT] = take_x;
         div_in[j+1].q_y[BIT] = take_y;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
         if (en[i+1]) div_ff[i] <= div_in[i];
      end
   end

   // source row times stride; destination offset sum
   mul_type mul_in, mul_ff;
   logic [COORD_WIDTH+STRIDE_WIDTH-1:0] prod_s;

   always_comb begin
      prod_s               = div_ff[DIV_STAGES].q_y * div_ff[DIV_STAGES].sstride;
      mul_in.sx            = div_ff[DIV_STAGES].q_x;
      mul_in.sy            = div_ff[DIV_STAGES].q_y;
      mul_in.prod_s        = prod_s[OFFSET_WIDTH-1:0];
      mul_in.target_offset = div_ff[DIV_STAGES].prod_t +
                             {{(OFFSET_WIDTH-COORD_WIDTH){1'b0}}, div_ff[DIV_STAGES].dx};
      mul_in.bad           = div_ff[DIV_STAGES].bad;
   end

   always_ff @(posedge clock) begin
      if (en[MUL_STAGE]) mul_ff <= mul_in;
   end

   // result register; rejected items read as zeros
   nnps_rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.bad_request = mul_ff.bad;
      if (mul_ff.bad) begin
         rsp_in.source_column = '0;
         rsp_in.source_row    = '0;
         rsp_in.source_offset = '0;
         rsp_in.target_offset = '0;
      end else begin
         rsp_in.source_column = mul_ff.sx;
         rsp_in.source_row    = mul_ff.sy;
         rsp_in.source_offset = mul_ff.prod_s +
                                {{(OFFSET_WIDTH-COORD_WIDTH){1'b0}}, mul_ff.sx};
         rsp_in.target_offset = mul_ff.target_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT_STAGE]) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: src/nnps_checker.sv
module nnps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input nnps_pkg::nnps_rsp_type rsp_data
);
   import nnps_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // rejected items carry all-zero fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_request |->
         rsp_data.source_column == '0 && rsp_data.source_row == '0 &&
         rsp_data.source_offset == '0 && rsp_data.target_offset == '0)
      else $error("bad item with nonzero fields");

   // an empty result register or a draining one never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input blocked with result side free");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind nearest_neighbor_plane_scaler_core nnps_checker u_nnps_checker (.*);

// File: verif/nearest_neighbor_plane_scaler_core_tb.sv
module nearest_neighbor_plane_scaler_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import nnps_pkg::*;

   localparam int unsigned CHROMA_SHRINK  = 2;
   localparam int unsigned IDLE_PERCENT   = 37;
   localparam int unsigned PHASE_COUNT    = 10;
   localparam int unsigned PHASE_ITEMS    = 95;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned CYCLE_LIMIT    = 200000;

   typedef struct packed {
      nnps_req_type stim;
      logic         typed;
      nnps_rsp_type want;
   } directed_row_type;

   localparam nnps_rsp_type REJECTED = '{bad_request: 1'b1, default: '0};
   localparam nnps_rsp_type UNTYPED  = '0;

   // typed rows assume the reset geometry: 1920x1080 luma, 960x540 chroma
   localparam directed_row_type DIRECTED_ROWS [16] = '{
      {12'd0,    12'd0,    1'b0, 1'b1, 12'd0, 12'd0, 25'd0, 25'd0, 1'b0},
      {12'd1919, 12'd1079, 1'b0, 1'b1, 12'd1919, 12'd1079, 25'd2073599, 25'd2073599, 1'b0},
      {12'd1920, 12'd0,    1'b0, 1'b1, REJECTED},
      {12'd0,    12'd1080, 1'b0, 1'b1, REJECTED},
      {12'd4095, 12'd4095, 1'b0, 1'b1, REJECTED},
      {12'd4095, 12'd0,    1'b0, 1'b1, REJECTED},
      {12'd0,    12'd4095, 1'b0, 1'b1, REJECTED},
      {12'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd0, 25'd0, 25'd0, 1'b0},
      {12'd959,  12'd539,  1'b1, 1'b1, 12'd959, 12'd539, 25'd518399, 25'd518399, 1'b0},
      {12'd960,  12'd0,    1'b1, 1'b1, REJECTED},
      {12'd0,    12'd540,  1'b1, 1'b1, REJECTED},
      {12'd4095, 12'd4095, 1'b1, 1'b1, REJECTED},
      {12'd1234, 12'd567,  1'b0, 1'b0, UNTYPED},
      {12'd100,  12'd200,  1'b1, 1'b0, UNTYPED},
      {12'd1000, 12'd1000, 1'b0, 1'b0, UNTYPED},
      {12'd1365, 12'd682,  1'b0, 1'b0, UNTYPED}
   };

   // register settings per phase; the last phases are drawn at random
   localparam int unsigned PHASE_SETTINGS [8][8] = '{
      '{4096, 4096, 4096, 4096, 8192, 8192, 8192, 8192},
      '{16383, 8292, 8193, 5000, 16383, 8193, 16383, 9000},
      '{1, 1, 1, 1, 1, 1, 1, 1},
      '{0, 33, 77, 0, 0, 0, 0, 0},
      '{640, 480, 1920, 1080, 640, 320, 2048, 1024},
      '{3840, 2160, 333, 17, 4000, 2000, 333, 170},
      '{3, 2, 4096, 4096, 3, 1, 8192, 0},
      '{4096, 4096, 1, 2, 8192, 4096, 1, 1}
   };

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   nnps_req_type          req_data         = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   nnps_rsp_type          rsp_data;
   logic                  csr_write_enable = 1'b0;
   csr_index_type         csr_index        = REG_SOURCE_WIDTH;
   logic [CSR_WIDTH-1:0]  csr_write_data   = '0;

   logic [CSR_WIDTH-1:0]  shadow_csr [8];
   nnps_rsp_type          pending_lookups [$];
   int unsigned           mismatch_count = 0;
   int unsigned           cycle_count    = 0;
   bit                    steady_flow    = 1'b0;

   nearest_neighbor_plane_scaler_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      shadow_csr[REG_SOURCE_WIDTH]         = CSR_WIDTH'(RESET_SOURCE_WIDTH);
      shadow_csr[REG_SOURCE_HEIGHT]        = CSR_WIDTH'(RESET_SOURCE_HEIGHT);
      shadow_csr[REG_TARGET_WIDTH]         = CSR_WIDTH'(RESET_TARGET_WIDTH);
      shadow_csr[REG_TARGET_HEIGHT]        = CSR_WIDTH'(RESET_TARGET_HEIGHT);
      shadow_csr[REG_LUMA_SOURCE_STRIDE]   = RESET_LUMA_STRIDE;
      shadow_csr[REG_CHROMA_SOURCE_STRIDE] = RESET_CHROMA_STRIDE;
      shadow_csr[REG_LUMA_TARGET_STRIDE]   = RESET_LUMA_STRIDE;
      shadow_csr[REG_CHROMA_TARGET_STRIDE] = RESET_CHROMA_STRIDE;
   end

   // plane size after saturation and, for chroma, halving
   function automatic int unsigned plane_size(csr_index_type idx, logic chroma);
      int unsigned v;
      v = shadow_csr[idx];
      if (v > MAX_DIMENSION) begin
         v = MAX_DIMENSION;
      end
      if (chroma) begin
         v = v / CHROMA_SHRINK;
      end
      return v;
   endfunction

   function automatic int unsigned stride_clamped(csr_index_type idx);
      int unsigned v;
      v = shadow_csr[idx];
      return (v > MAX_STRIDE) ? MAX_STRIDE : v;
   endfunction

   function automatic nnps_rsp_type scale_lookup(nnps_req_type item);
      nnps_rsp_type  p;
      int unsigned   sw, sh, dw, dh, ss, ds, sx, sy;
      sw = plane_size(REG_SOURCE_WIDTH, item.chroma_plane);
      sh = plane_size(REG_SOURCE_HEIGHT, item.chroma_plane);
      dw = plane_size(REG_TARGET_WIDTH, item.chroma_plane);
      dh = plane_size(REG_TARGET_HEIGHT, item.chroma_plane);
      ss = stride_clamped(item.chroma_plane ? REG_CHROMA_SOURCE_STRIDE
                                            : REG_LUMA_SOURCE_STRIDE);
      ds = stride_clamped(item.chroma_plane ? REG_CHROMA_TARGET_STRIDE
                                            : REG_LUMA_TARGET_STRIDE);
      p = '0;
      if (sw == 0 || sh == 0 || dw == 0 || dh == 0 ||
          item.target_column >= dw || item.target_row >= dh) begin
         p.bad_request = 1'b1;
      end else begin
         sx = (item.target_column * sw) / dw;
         sy = (item.target_row * sh) / dh;
         p.source_column = COORD_WIDTH'(sx);
         p.source_row    = COORD_WIDTH'(sy);
         p.source_offset = OFFSET_WIDTH'(sy * ss + sx);
         p.target_offset = OFFSET_WIDTH'(item.target_row * ds + item.target_column);
      end
      return p;
   endfunction

   // mostly pixels inside the plane, some on its edge, the rest anywhere
   function automatic nnps_req_type pick_item();
      nnps_req_type  item;
      int unsigned   cols, rows, mode;
      item.chroma_plane = 1'($urandom_range(1));
      cols = plane_size(REG_TARGET_WIDTH, item.chroma_plane);
      rows = plane_size(REG_TARGET_HEIGHT, item.chroma_plane);
      mode = $urandom_range(99);
      if (mode < 75 && cols != 0 && rows != 0) begin
         item.target_column = COORD_WIDTH'($urandom_range(cols - 1));
         item.target_row    = COORD_WIDTH'($urandom_range(rows - 1));
      end else if (mode < 87) begin
         item.target_column = COORD_WIDTH'(cols - $urandom_range(1));
         item.target_row    = COORD_WIDTH'(rows - $urandom_range(1));
      end else begin
         item.target_column = COORD_WIDTH'($urandom);
         item.target_row    = COORD_WIDTH'($urandom);
      end
      return item;
   endfunction

   // called and returns at a falling edge; valid is left high after acceptance
   task automatic offer_item(input nnps_req_type item, input logic typed,
                             input nnps_rsp_type want);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_lookups.push_back(typed ? want : scale_lookup(item));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_lookups.size() != 0) @(negedge clock);
   endtask

   task automatic load_settings(input int unsigned values [8]);
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_write_data   <= CSR_WIDTH'(values[i]);
         shadow_csr[i] = (i <= REG_TARGET_HEIGHT) ? CSR_WIDTH'(SIZE_WIDTH'(values[i]))
                                                  : CSR_WIDTH'(values[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      nnps_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: col %0d row %0d src %0d dst %0d bad %0b",
                        rsp_data.source_column, rsp_data.source_row,
                        rsp_data.source_offset, rsp_data.target_offset,
                        rsp_data.bad_request);
            end
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.source_column !== want.source_column ||
                rsp_data.source_row    !== want.source_row    ||
                rsp_data.source_offset !== want.source_offset ||
                rsp_data.target_offset !== want.target_offset ||
                rsp_data.bad_request   !== want.bad_request) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected col %0d row %0d src %0d dst %0d bad %0b",
                           want.source_column, want.source_row, want.source_offset,
                           want.target_offset, want.bad_request);
                  $display("          actual   col %0d row %0d src %0d dst %0d bad %0b",
                           rsp_data.source_column, rsp_data.source_row,
                           rsp_data.source_offset, rsp_data.target_offset,
                           rsp_data.bad_request);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned settings [8];
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         offer_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         if (p < 8) begin
            settings = PHASE_SETTINGS[p];
         end else begin
            for (int i = 0; i < 8; i++) begin
               settings[i] = (i <= REG_TARGET_HEIGHT) ? $urandom_range(4096, 1)
                                                       : $urandom_range(8192, 1);
            end
         end
         load_settings(settings);
         steady_flow = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the pipeline run dry once in the middle of a phase
            if (p == 5 && n == 40) begin
               drain();
            end
            offer_item(pick_item(), 1'b0, UNTYPED);
         end
      end

      drain();
      steady_flow = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
